// ===== sv/mwgp_pkg.sv =====
// Package for the mixed-width glyph placer: payload types, codes and constants.
package mwgp_pkg;

   // Default panel width in pixel columns
   localparam int DISPLAY_WIDTH_DEFAULT = 128;

   // Controller RAM is wider than the panel
   localparam logic [8:0] RAM_COLUMNS = 9'd132;
   localparam logic [8:0] WIDE_RAM_LIMIT = RAM_COLUMNS - 9'd16;
   localparam logic [8:0] NARROW_RAM_LIMIT = RAM_COLUMNS - 9'd8;

   // Glyph kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ASCII = 2'd1;
   localparam logic [1:0] KIND_HANZI = 2'd2;
   localparam logic [1:0] KIND_SPACE = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] REG_START_LINE = 3'd0;
   localparam logic [2:0] REG_START_COLUMN = 3'd1;
   localparam logic [2:0] REG_INVERT = 3'd2;
   localparam logic [2:0] REG_ASCII_BASE = 3'd3;
   localparam logic [2:0] REG_HANZI_BASE = 3'd4;

   // Code points and font layout
   localparam logic [7:0] WIDE_THRESHOLD = 8'h80;
   localparam logic [7:0] GB_FIRST = 8'hA1;
   localparam logic [7:0] FF_LEAD = 8'hFF;
   localparam logic [7:0] SUB_HI = 8'hA3;
   localparam logic [7:0] SUB_LO = 8'hC0;
   localparam logic [14:0] GB_ROW_SIZE = 15'd94;
   localparam logic [19:0] SPACE_OFFSET = 20'h00200;
   localparam logic [5:0] ASCII_BYTES = 6'd16;
   localparam logic [5:0] HANZI_BYTES = 6'd32;
   localparam logic [2:0] LAST_ROW = 3'd4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  glyph_kind;
      logic [19:0] font_address;
      logic [5:0]  byte_count;
      logic [6:0]  column;
      logic [2:0]  upper_page;
      logic [2:0]  lower_page;
      logic        invert_out;
      logic        bad_code;
      logic        end_of_string;
      logic        last_of_run;
   } rsp_payload_type;

   // Text rows 1..4 sit on upper pages 3,1,7,5
   function automatic logic [2:0] page_of_row(input logic [2:0] row);
      logic [2:0] page;
      case (row)
         3'd1: page = 3'd3;
         3'd2: page = 3'd1;
         3'd3: page = 3'd7;
         3'd4: page = 3'd5;
         default: page = 3'd0;
      endcase
      return page;
   endfunction

endpackage

// ===== sv/mixed_width_text_glyph_placer_unit.sv =====
// Top level of the mixed-width glyph placer: layout logic, result register and CSR port.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_valid / req_ready  | req_data: text byte, last flag
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_data: one placed glyph
//  csr     | in        | psel / penable, pready | 5 registers at 4*index, 32 bits
//
// One text byte is taken every cycle; each byte yields zero or one result in the
// next cycle, held in the single result register that the layout logic feeds.
// The input stalls only while that result register is full and rsp_ready is low.
// reset is synchronous, active high; it restores register defaults and starts a
// fresh string, with no clearing pass.
module mixed_width_text_glyph_placer_unit #(
   parameter int DISPLAY_WIDTH = mwgp_pkg::DISPLAY_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mwgp_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mwgp_pkg::rsp_payload_type rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [4:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import mwgp_pkg::*;

   localparam logic [8:0] WideLimit = 9'(DISPLAY_WIDTH - 16);
   localparam logic [8:0] NarrowLimit = 9'(DISPLAY_WIDTH - 8);

   // Configuration registers
   logic [2:0]  start_line_ff;
   logic [7:0]  start_column_ff;
   logic        invert_ff;
   logic [19:0] ascii_base_ff;
   logic [19:0] hanzi_base_ff;

   // Layout state
   logic [2:0] row_ff, row_in;
   logic [7:0] column_ff, column_in;
   logic [7:0] lead_ff, lead_in;
   logic       pending_ff, pending_in;
   logic       stopped_ff, stopped_in;
   logic       fresh_ff, fresh_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic       csr_write;
   logic       emit;
   logic       wide;
   logic       wrap;
   logic [2:0] row_eff;
   logic [7:0] column_eff;
   logic       pending_eff;
   logic       stopped_eff;
   logic [7:0] hi_byte;
   logic [7:0] lo_byte;
   logic [14:0] gb_index;
   logic [2:0]  page;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_line_ff <= 3'd1;
         start_column_ff <= 8'd0;
         invert_ff <= 1'b0;
         ascii_base_ff <= 20'h40000;
         hanzi_base_ff <= 20'h00000;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            REG_START_LINE: start_line_ff <= pwdata[2:0];
            REG_START_COLUMN: start_column_ff <= pwdata[7:0];
            REG_INVERT: invert_ff <= pwdata[0];
            REG_ASCII_BASE: ascii_base_ff <= pwdata[19:0];
            REG_HANZI_BASE: hanzi_base_ff <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      unique case (paddr[4:2])
         REG_START_LINE: prdata = {29'd0, start_line_ff};
         REG_START_COLUMN: prdata = {24'd0, start_column_ff};
         REG_INVERT: prdata = {31'd0, invert_ff};
         REG_ASCII_BASE: prdata = {12'd0, ascii_base_ff};
         REG_HANZI_BASE: prdata = {12'd0, hanzi_base_ff};
         default: prdata = 32'd0;
      endcase
   end

   // Place the glyph for this byte and work out the next position
   always_comb begin
      // A fresh string reloads its position from configuration
      row_eff = fresh_ff ? start_line_ff : row_ff;
      column_eff = fresh_ff ? start_column_ff : column_ff;
      pending_eff = fresh_ff ? 1'b0 : pending_ff;
      stopped_eff = fresh_ff ? (start_line_ff < 3'd1 || start_line_ff > LAST_ROW ||
                                {1'b0, start_column_ff} > WideLimit)
                             : stopped_ff;

      row_in = row_eff;
      column_in = column_eff;
      lead_in = lead_ff;
      pending_in = pending_eff;
      stopped_in = stopped_eff;
      fresh_in = 1'b0;
      emit = 1'b0;
      rsp_data_in = '0;
      wide = req_data.text_byte > WIDE_THRESHOLD;
      wrap = 1'b0;

      // Substitute the full-width lead code and index the GB2312 table
      hi_byte = lead_ff;
      lo_byte = req_data.text_byte;
      if (hi_byte == FF_LEAD) begin
         hi_byte = SUB_HI;
         lo_byte = SUB_LO;
      end
      gb_index = 15'(({7'd0, hi_byte} - {7'd0, GB_FIRST}) * GB_ROW_SIZE) +
                 ({7'd0, lo_byte} - {7'd0, GB_FIRST});

      if (!stopped_eff) begin
         if (pending_eff) begin
            // Trail byte completes a wide glyph
            if ({1'b0, column_eff} <= WIDE_RAM_LIMIT) begin
               emit = 1'b1;
               rsp_data_in.glyph_kind = KIND_HANZI;
               rsp_data_in.font_address = hanzi_base_ff + {gb_index, 5'd0};
               rsp_data_in.byte_count = HANZI_BYTES;
               rsp_data_in.column = column_eff[6:0];
               rsp_data_in.bad_code = (hi_byte < GB_FIRST) || (lo_byte < GB_FIRST);
            end
            column_in = column_eff + 8'd16;
            pending_in = 1'b0;
         end else begin
            // Wrap check on the first byte of a character
            wrap = {1'b0, column_eff} > (wide ? WideLimit : NarrowLimit);
            if (wrap) begin
               if (wide && {1'b0, column_eff} <= NARROW_RAM_LIMIT) begin
                  emit = 1'b1;
                  rsp_data_in.glyph_kind = KIND_SPACE;
                  rsp_data_in.font_address = ascii_base_ff + SPACE_OFFSET;
                  rsp_data_in.byte_count = ASCII_BYTES;
                  rsp_data_in.column = column_eff[6:0];
               end
               column_in = 8'd0;
               row_in = row_eff + 3'd1;
               if (row_in > LAST_ROW || row_in == 3'd0) begin
                  stopped_in = 1'b1;
               end
            end
            if (!stopped_in) begin
               if (wide) begin
                  lead_in = req_data.text_byte;
                  pending_in = 1'b1;
               end else begin
                  if ({1'b0, column_in} <= NARROW_RAM_LIMIT) begin
                     emit = 1'b1;
                     rsp_data_in.glyph_kind = KIND_ASCII;
                     rsp_data_in.font_address = ascii_base_ff +
                                                {8'd0, req_data.text_byte, 4'd0};
                     rsp_data_in.byte_count = ASCII_BYTES;
                     rsp_data_in.column = column_in[6:0];
                  end
                  column_in = column_in + 8'd8;
               end
            end
         end
      end

      // Page pair follows the row the glyph was drawn on
      page = page_of_row(wrap && rsp_data_in.glyph_kind != KIND_SPACE ? row_in : row_eff);
      if (emit) begin
         rsp_data_in.upper_page = page;
         rsp_data_in.lower_page = page - 3'd1;
         rsp_data_in.invert_out = invert_ff;
      end

      // Close the string on its last byte
      if (req_data.last_byte) begin
         if (!emit) begin
            rsp_data_in = '0;
            emit = 1'b1;
         end
         rsp_data_in.end_of_string = 1'b1;
         fresh_in = 1'b1;
         pending_in = 1'b0;
         stopped_in = 1'b0;
      end
      rsp_data_in.last_of_run = emit;

      // Load the result register on a transaction, drain it when taken
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Advance layout state and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
         pending_ff <= 1'b0;
         stopped_ff <= 1'b0;
         lead_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            fresh_ff <= fresh_in;
            pending_ff <= pending_in;
            stopped_ff <= stopped_in;
            lead_ff <= lead_in;
         end
      end
   end

   // Hold position and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         row_ff <= row_in;
         column_ff <= column_in;
         if (emit) begin
            rsp_data_ff <= rsp_data_in;
         end
      end
   end

`ifndef SYNTHESIS
   // The last byte of a string always leaves a closing result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_byte) |=>
      (rsp_valid && rsp_data.end_of_string))
      else $error("last byte did not produce an end-of-string result");

   // An empty result register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // An end-only result is empty and closes the string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.glyph_kind == KIND_NONE) |->
      (rsp_data.end_of_string && rsp_data.byte_count == 6'd0 &&
       rsp_data.font_address == 20'd0))
      else $error("malformed end-only result");
`endif

endmodule
